// ===== hdl/eutc_pkg.sv =====
// ----------------------------------------------------------------------------
// eutc_pkg: shared types for the epoch seconds to UTC calendar converter
// Payload structs carried by the input and output channels.
// ----------------------------------------------------------------------------
package eutc_pkg;

  typedef struct packed {
    logic signed [63:0] epoch_seconds;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [5:0]         second_of_minute;
    logic [5:0]         minute_of_hour;
    logic [4:0]         hour_of_day;
    logic [4:0]         day_of_month;
    logic [3:0]         month_index;
    logic signed [31:0] years_since_1900;
    logic [2:0]         weekday;
    logic [8:0]         day_of_year;
  } out_item_t;

endpackage

// ===== hdl/eutc_if.sv =====
// ----------------------------------------------------------------------------
// eutc_if: valid/ready channels of the epoch seconds to UTC calendar converter
// One interface for the timestamp input, one for the calendar output.
// ----------------------------------------------------------------------------
interface eutc_in_if;
  import eutc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eutc_out_if;
  import eutc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/epoch_seconds_to_utc_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar: signed epoch seconds to broken-down UTC time
//
// in_i carries one signed 64-bit count of seconds since 1970-01-01 UTC per
// transaction; out_o returns one calendar result per transaction: second,
// minute, hour, day of month, month 0..11, years since 1900, weekday
// (Sunday = 0), day of year, and a status bit set when the year does not
// fit in 32 bits (all other fields are then zero).
// The datapath is a 14-stage pipeline, the last stage being the output
// register. Throughput is one transaction per cycle while out_o.ready is
// high; the rate is set by the pipeline, with the reciprocal multiplies and
// wide adds spread over the stages ahead of the output register.
// Each stage advances unless it and every stage after it are full while
// out_o.ready is low, so empty stages keep absorbing input during a stall
// and nothing is dropped or repeated.
// Reset empties the pipeline; in_i.ready is high right after reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar (
  input  logic       clk_i,
  input  logic       rst_ni,
  eutc_in_if.sink    in_i,
  eutc_out_if.source out_o
);
  import eutc_pkg::*;

  localparam int unsigned NumStages  = 14;
  localparam int unsigned WorkStages = NumStages - 1;

  localparam logic [63:0] DaySecs    = 64'd86400;
  localparam logic [63:0] EraDays    = 64'd146097;
  localparam logic [63:0] EraDiv     = (DaySecs >> 7) * EraDays;
  localparam logic [63:0] EraSecs    = DaySecs * EraDays;
  localparam logic [63:0] EpochShift = 64'd719468 * DaySecs;
  localparam logic [63:0] BiasSecs   = (64'd1 << 63) - EpochShift;
  localparam logic [63:0] EraBias    = BiasSecs / EraSecs;
  localparam logic [63:0] EraBiasRem = BiasSecs % EraSecs;
  localparam logic [63:0] EraRecip   = (64'd1 << 57) / EraDiv;

  localparam int unsigned Sh675   = 40;
  localparam int unsigned Sh1460  = 30;
  localparam int unsigned Sh36524 = 35;
  localparam int unsigned Sh3600  = 30;
  localparam int unsigned Sh7     = 22;
  localparam int unsigned Sh365   = 28;
  localparam int unsigned Sh100   = 17;
  localparam int unsigned Sh60    = 19;
  localparam int unsigned Sh153   = 20;
  localparam int unsigned Sh5     = 15;

  localparam logic [31:0] Recip675   = 32'((64'd1 << Sh675) / 64'd675 + 64'd1);
  localparam logic [31:0] Recip1460  = 32'((64'd1 << Sh1460) / 64'd1460 + 64'd1);
  localparam logic [31:0] Recip36524 = 32'((64'd1 << Sh36524) / 64'd36524 + 64'd1);
  localparam logic [31:0] Recip3600  = 32'((64'd1 << Sh3600) / 64'd3600 + 64'd1);
  localparam logic [31:0] Recip7     = 32'((64'd1 << Sh7) / 64'd7 + 64'd1);
  localparam logic [31:0] Recip365   = 32'((64'd1 << Sh365) / 64'd365 + 64'd1);
  localparam logic [31:0] Recip100   = 32'((64'd1 << Sh100) / 64'd100 + 64'd1);
  localparam logic [31:0] Recip60    = 32'((64'd1 << Sh60) / 64'd60 + 64'd1);
  localparam logic [31:0] Recip153   = 32'((64'd1 << Sh153) / 64'd153 + 64'd1);
  localparam logic [31:0] Recip5     = 32'((64'd1 << Sh5) / 64'd5 + 64'd1);

  typedef struct packed {
    logic [63:0]        u;
    logic [30:0]        q_est;
    logic [56:0]        prod;
    logic [28:0]        r;
    logic [30:0]        qu;
    logic [33:0]        ru;
    logic [33:0]        t;
    logic signed [31:0] era;
    logic [17:0]        doe;
    logic [16:0]        rem;
    logic [6:0]         a1;
    logic [2:0]         a2;
    logic               a3;
    logic [17:0]        n;
    logic [4:0]         hour;
    logic [14:0]        q7;
    logic [8:0]         yoe;
    logic [11:0]        rh;
    logic [2:0]         wd;
    logic [1:0]         yc;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [8:0]         doy;
    logic               leap;
    logic signed [40:0] yr_m;
    logic [3:0]         mp;
    logic [4:0]         mday;
    logic [3:0]         month;
    logic signed [40:0] ydiff;
    logic [8:0]         yday;
  } work_t;

  // x * m >> sh, with m a rounded-up reciprocal sized so the result is exact
  function automatic logic [31:0] mul_shr(input logic [31:0] x, input logic [31:0] m,
                                          input int unsigned sh);
    logic [63:0] p;
    p = {32'd0, x} * {32'd0, m};
    return 32'(p >> sh);
  endfunction

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;
  work_t                st_q [WorkStages];
  work_t                st_d [WorkStages];
  out_item_t            out_q;
  out_item_t            out_d;

  // stage k moves unless it and all stages after it hold data and the sink stalls
  always_comb begin
    logic [NumStages-1:0] mask;
    for (int k = 0; k < NumStages; k++) begin
      mask   = {NumStages{1'b1}} << k;
      adv[k] = out_o.ready || !(&(vld_q | ~mask));
    end
  end

  assign in_i.ready  = adv[0];
  assign out_o.valid = vld_q[NumStages-1];
  assign out_o.data  = out_q;

  always_comb begin : stage_logic
    logic [63:0] prod0;
    logic [28:0] r_c;
    logic        ge1;
    logic        ge2;
    logic        borrow;
    logic [26:0] xd;
    logic [26:0] rem7;
    logic [17:0] dp3;
    logic [10:0] m5;
    logic [10:0] m153;
    logic [8:0]  dm;
    logic        jan_feb;

    // 0: era quotient estimate from the top 32 bits of the biased seconds
    st_d[0]       = '0;
    st_d[0].u     = {~in_i.data.epoch_seconds[63], in_i.data.epoch_seconds[62:0]};
    prod0         = {32'd0, st_d[0].u[63:32]} * {33'd0, EraRecip[30:0]};
    st_d[0].q_est = prod0[62:32];

    // 1: back-multiply the estimate
    st_d[1]      = st_q[0];
    st_d[1].prod = 57'({27'd0, st_q[0].q_est} * {31'd0, EraDiv[26:0]});

    // 2: partial remainder, below three divisors
    st_d[2]   = st_q[1];
    st_d[2].r = 29'(st_q[1].u[63:7] - st_q[1].prod);

    // 3: quotient correction
    st_d[3] = st_q[2];
    ge2     = st_q[2].r >= 29'(EraDiv * 64'd2);
    ge1     = st_q[2].r >= 29'(EraDiv);
    priority if (ge2) begin
      r_c         = st_q[2].r - 29'(EraDiv * 64'd2);
      st_d[3].qu  = st_q[2].q_est + 31'd2;
    end else if (ge1) begin
      r_c         = st_q[2].r - 29'(EraDiv);
      st_d[3].qu  = st_q[2].q_est + 31'd1;
    end else begin
      r_c         = st_q[2].r;
      st_d[3].qu  = st_q[2].q_est;
    end
    st_d[3].ru = {r_c[26:0], st_q[2].u[6:0]};

    // 4: remove the bias, floored
    st_d[4] = st_q[3];
    borrow  = st_q[3].ru < 34'(EraBiasRem);
    st_d[4].t = borrow ? st_q[3].ru + 34'(EraSecs - EraBiasRem)
                       : st_q[3].ru - 34'(EraBiasRem);
    st_d[4].era = signed'(32'({1'b0, st_q[3].qu}) - 32'(EraBias) - {31'd0, borrow});

    // 5: day of era
    st_d[5]     = st_q[4];
    xd          = st_q[4].t[33:7];
    st_d[5].doe = 18'(mul_shr({5'd0, xd}, Recip675, Sh675));

    // 6: second of day and leap-cycle corrections
    st_d[6]     = st_q[5];
    rem7        = st_q[5].t[33:7] - 27'({9'd0, st_q[5].doe} * 27'd675);
    st_d[6].rem = {rem7[9:0], st_q[5].t[6:0]};
    st_d[6].a1  = 7'(mul_shr({14'd0, st_q[5].doe}, Recip1460, Sh1460));
    st_d[6].a2  = 3'(mul_shr({14'd0, st_q[5].doe}, Recip36524, Sh36524));
    st_d[6].a3  = st_q[5].doe == 18'd146096;

    // 7
    st_d[7]      = st_q[6];
    st_d[7].n    = st_q[6].doe - {11'd0, st_q[6].a1} + {15'd0, st_q[6].a2}
                   - {17'd0, st_q[6].a3};
    st_d[7].hour = 5'(mul_shr({15'd0, st_q[6].rem}, Recip3600, Sh3600));
    dp3          = st_q[6].doe + 18'd3;
    st_d[7].q7   = 15'(mul_shr({14'd0, dp3}, Recip7, Sh7));

    // 8: year of era, weekday (an era is a whole number of weeks)
    st_d[8]     = st_q[7];
    st_d[8].yoe = 9'(mul_shr({14'd0, st_q[7].n}, Recip365, Sh365));
    st_d[8].rh  = 12'(st_q[7].rem - 17'({12'd0, st_q[7].hour} * 17'd3600));
    st_d[8].wd  = 3'(st_q[7].doe + 18'd3 - 18'({3'd0, st_q[7].q7} * 18'd7));

    // 9
    st_d[9]        = st_q[8];
    st_d[9].yc     = 2'(mul_shr({23'd0, st_q[8].yoe}, Recip100, Sh100));
    st_d[9].minute = 6'(mul_shr({20'd0, st_q[8].rh}, Recip60, Sh60));

    // 10: day of March-based year, year number
    st_d[10]        = st_q[9];
    st_d[10].doy    = 9'(st_q[9].doe - (18'({9'd0, st_q[9].yoe} * 18'd365)
                      + 18'(st_q[9].yoe >> 2) - 18'(st_q[9].yc)));
    st_d[10].second = 6'(st_q[9].rh - 12'({6'd0, st_q[9].minute} * 12'd60));
    st_d[10].leap   = (st_q[9].yoe[1:0] == 2'd0) &&
                      ((st_q[9].yoe != 9'({7'd0, st_q[9].yc} * 9'd100)) ||
                       (st_q[9].yoe == 9'd0));
    st_d[10].yr_m   = 41'(st_q[9].era) * 41'sd400 + signed'({32'd0, st_q[9].yoe});

    // 11: month of March-based year
    st_d[11]    = st_q[10];
    m5          = 11'({2'd0, st_q[10].doy} * 11'd5) + 11'd2;
    st_d[11].mp = 4'(mul_shr({21'd0, m5}, Recip153, Sh153));

    // 12: calendar month, day, year and day of year
    st_d[12]       = st_q[11];
    m153           = 11'({7'd0, st_q[11].mp} * 11'd153) + 11'd2;
    dm             = 9'(mul_shr({21'd0, m153}, Recip5, Sh5));
    st_d[12].mday  = 5'(st_q[11].doy - dm + 9'd1);
    jan_feb        = st_q[11].mp >= 4'd10;
    st_d[12].month = jan_feb ? st_q[11].mp - 4'd10 : st_q[11].mp + 4'd2;
    st_d[12].ydiff = st_q[11].yr_m - 41'sd1900 + signed'({40'd0, jan_feb});
    st_d[12].yday  = jan_feb ? st_q[11].doy - 9'd306
                             : st_q[11].doy + 9'd59 + {8'd0, st_q[11].leap};
  end

  always_comb begin
    work_t w;
    w     = st_q[WorkStages-1];
    out_d = '0;
    if (w.ydiff[40:31] != {10{w.ydiff[31]}}) begin
      out_d.status = 1'b1;
    end else begin
      out_d.second_of_minute = w.second;
      out_d.minute_of_hour   = w.minute;
      out_d.hour_of_day      = w.hour;
      out_d.day_of_month     = w.mday;
      out_d.month_index      = w.month;
      out_d.years_since_1900 = signed'(w.ydiff[31:0]);
      out_d.weekday          = w.wd;
      out_d.day_of_year      = w.yday;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < WorkStages; k++) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
    if (adv[NumStages-1]) begin
      out_q <= out_d;
    end
  end

  // an accepted transaction with no delivery adds exactly one item in flight
  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !(out_o.valid && out_o.ready))
    |=> ($countones(vld_q) == $past($countones(vld_q)) + 1))
    else $error("pipeline occupancy mismatch");

  a_fields_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.status) |->
    (out_o.data.month_index <= 4'd11 && out_o.data.hour_of_day <= 5'd23 &&
     out_o.data.minute_of_hour <= 6'd59 && out_o.data.second_of_minute <= 6'd59 &&
     out_o.data.weekday <= 3'd6 && out_o.data.day_of_month != 5'd0 &&
     out_o.data.day_of_year <= 9'd365))
    else $error("calendar field out of range");

  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.status) |->
    (out_o.data.years_since_1900 == 32'sd0 && out_o.data.day_of_month == 5'd0 &&
     out_o.data.day_of_year == 9'd0 && out_o.data.weekday == 3'd0))
    else $error("fields not cleared on year overflow");

  a_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(&vld_q[NumStages-2:0])) |-> in_i.ready)
    else $error("input stalled while pipeline has room");

endmodule

// ===== sim/epoch_seconds_to_utc_calendar_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar_test: self-checking bench for the UTC converter
// Drives signed epoch seconds through the valid/ready input with random gaps
// and output stalls. A directed list covers the epoch, leap days, century
// years, the 64-bit extremes and the edges of the 32-bit year range. Random
// stamps follow. Some directed stamps are checked against fixed values, all
// others against a local floored-division, 400-year-era calendar computation.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar_test;
  import eutc_pkg::*;

  localparam int     RAND_COUNT   = 1225;
  localparam int     CALM_TAIL    = 150;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     MAX_REPORTS  = 10;
  localparam int     DRAIN_CYCLES = 20;
  localparam longint YEAR_LOW     = -64'sd2147483648;
  localparam longint YEAR_HIGH    = 64'sd2147483647;

  typedef struct {
    longint    stamp;
    bit        typed;
    out_item_t want;
  } probe_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  eutc_in_if  stamp_bus ();
  eutc_out_if cal_bus ();

  out_item_t  stamp_want;
  out_item_t  calendar_due [$];
  probe_row_t probe_list [$];
  longint     year_edge [4];
  int         miss_count = 0;
  bit         gaps_on    = 1'b1;
  bit         calm       = 1'b0;

  epoch_seconds_to_utc_calendar dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stamp_bus),
    .out_o  (cal_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // day number of January 1 of calendar year yr, counted from 1970-01-01
  function automatic longint new_year_day(longint yr);
    longint ym, era, yoe;
    ym  = yr - 1;
    era = floor_quot(ym, 400);
    yoe = ym - era * 400;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + 306 - 719468;
  endfunction

  function automatic out_item_t calendar_of(longint secs);
    longint    days, rem, z, era, doe, yoe, yr, doy, mp, mday, mon, ydiff, wd;
    out_item_t r;
    r    = '0;
    days = secs / 86400;
    rem  = secs % 86400;
    if (rem < 0) begin
      rem  = rem + 86400;
      days = days - 1;
    end
    z    = days + 719468;
    era  = floor_quot(z, 146097);
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr   = yoe + era * 400;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    mday = doy - (153 * mp + 2) / 5 + 1;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    if (mon <= 2) yr = yr + 1;
    ydiff = yr - 1900;
    if (ydiff < YEAR_LOW || ydiff > YEAR_HIGH) begin
      r.status = 1'b1;
      return r;
    end
    wd = (days + 4) % 7;
    if (wd < 0) wd = wd + 7;
    r.second_of_minute = 6'(rem % 60);
    r.minute_of_hour   = 6'((rem / 60) % 60);
    r.hour_of_day      = 5'(rem / 3600);
    r.day_of_month     = 5'(mday);
    r.month_index      = 4'(mon - 1);
    r.years_since_1900 = 32'(ydiff);
    r.weekday          = 3'(wd);
    r.day_of_year      = 9'(days - new_year_day(yr));
    return r;
  endfunction

  function automatic out_item_t make_cal(bit st, int sec, int mi, int hr, int md, int mo,
                                         int yr, int wd, int yd);
    out_item_t c;
    c.status           = st;
    c.second_of_minute = 6'(sec);
    c.minute_of_hour   = 6'(mi);
    c.hour_of_day      = 5'(hr);
    c.day_of_month     = 5'(md);
    c.month_index      = 4'(mo);
    c.years_since_1900 = 32'(yr);
    c.weekday          = 3'(wd);
    c.day_of_year      = 9'(yd);
    return c;
  endfunction

  function automatic string cal_text(out_item_t c);
    return $sformatf("st=%0d s=%0d m=%0d h=%0d d=%0d mo=%0d y=%0d wd=%0d yd=%0d",
                     c.status, c.second_of_minute, c.minute_of_hour, c.hour_of_day,
                     c.day_of_month, c.month_index, c.years_since_1900, c.weekday,
                     c.day_of_year);
  endfunction

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint next_stamp();
    longint yr, day, s;
    case ($urandom_range(0, 9))
      0: s = longint'(rand64());
      1, 2, 3: s = longint'(rand64()) >>> $urandom_range(0, 63);
      4, 5: begin
        yr  = longint'($urandom_range(0, 4000000)) - 64'sd2000000;
        day = new_year_day(yr);
        case ($urandom_range(0, 3))
          0: day = day;
          1: day = day + 59;
          2: day = day + 60;
          default: day = day + 365;
        endcase
        s = day * 86400 + longint'($urandom_range(0, 172800)) - 64'sd86400;
      end
      6: s = year_edge[$urandom_range(0, 3)] + longint'($urandom_range(0, 2000000))
             - 64'sd1000000;
      default: s = longint'(rand64() % 64'd6311433600) - 64'sd2208988800;
    endcase
    return s;
  endfunction

  task automatic add_probe(longint s, bit typed, out_item_t want);
    probe_row_t row;
    row.stamp = s;
    row.typed = typed;
    row.want  = want;
    probe_list.push_back(row);
  endtask

  task automatic send_stamp(longint s, out_item_t want);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      stamp_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    stamp_bus.valid              <= 1'b1;
    stamp_bus.data.epoch_seconds <= s;
    stamp_want                   <= want;
    @(posedge clk_i);
    while (!stamp_bus.ready) @(posedge clk_i);
  endtask

  task automatic report_miss(string what, out_item_t want, out_item_t got, bit has_want);
    miss_count++;
    if (miss_count <= MAX_REPORTS) begin
      if (has_want) $display("mismatch %s: exp %s", what, cal_text(want));
      else $display("mismatch %s", what);
      $display("              got %s", cal_text(got));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stamp_bus.valid && stamp_bus.ready) calendar_due.push_back(stamp_want);
      if (cal_bus.valid && cal_bus.ready) begin
        if (calendar_due.size() == 0) begin
          report_miss("unexpected transaction", '0, cal_bus.data, 1'b0);
        end else begin
          if (cal_bus.data !== calendar_due[0]) begin
            report_miss("calendar", calendar_due[0], cal_bus.data, 1'b1);
          end
          void'(calendar_due.pop_front());
        end
      end
    end
  end

  initial begin
    cal_bus.ready <= 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
        cal_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      cal_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL epoch_seconds_to_utc_calendar");
    $finish;
  end

  initial begin
    stamp_bus.valid <= 1'b0;
    stamp_bus.data  <= '0;
    stamp_want      <= '0;
    rst_ni          <= 1'b0;

    year_edge[0] = new_year_day(YEAR_HIGH + 1901) * 86400 - 1;
    year_edge[1] = year_edge[0] + 1;
    year_edge[2] = new_year_day(YEAR_LOW + 1900) * 86400;
    year_edge[3] = year_edge[2] - 1;

    add_probe(64'sd0, 1'b1, make_cal(0, 0, 0, 0, 1, 0, 70, 4, 0));
    add_probe(-64'sd1, 1'b1, make_cal(0, 59, 59, 23, 31, 11, 69, 3, 364));
    add_probe(64'sd86399, 1'b1, make_cal(0, 59, 59, 23, 1, 0, 70, 4, 0));
    add_probe(64'sd86400, 1'b1, make_cal(0, 0, 0, 0, 2, 0, 70, 5, 1));
    add_probe(64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, make_cal(1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(64'sh8000_0000_0000_0000, 1'b1, make_cal(1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_probe(-64'sd86400, 1'b0, '0);
    add_probe(-64'sd86401, 1'b0, '0);
    add_probe(64'sd946684799, 1'b0, '0);
    add_probe(64'sd946684800, 1'b0, '0);
    add_probe(64'sd951782400, 1'b0, '0);
    add_probe(64'sd951868800, 1'b0, '0);
    add_probe(64'sd978307199, 1'b0, '0);
    add_probe(-64'sd2208988800, 1'b0, '0);
    add_probe(-64'sd2203891200, 1'b0, '0);
    add_probe(64'sd4107542400, 1'b0, '0);
    add_probe(64'sd253402300799, 1'b0, '0);
    add_probe(-64'sd62135596800, 1'b0, '0);
    add_probe(-64'sd62167219200, 1'b0, '0);
    add_probe(64'sd2147483647, 1'b0, '0);
    add_probe(-64'sd2147483648, 1'b0, '0);
    foreach (year_edge[k]) add_probe(year_edge[k], 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (probe_list[k]) begin
      send_stamp(probe_list[k].stamp,
                 probe_list[k].typed ? probe_list[k].want : calendar_of(probe_list[k].stamp));
    end

    for (int n = 0; n < RAND_COUNT; n++) begin
      longint s;
      gaps_on = ((n / 100) % 3) != 2;
      calm    = n >= RAND_COUNT - CALM_TAIL;
      s = next_stamp();
      send_stamp(s, calendar_of(s));
    end
    stamp_bus.valid <= 1'b0;

    while (calendar_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    miss_count += calendar_due.size();

    if (miss_count == 0) begin
      $display("PASS epoch_seconds_to_utc_calendar");
    end else begin
      $display("FAIL epoch_seconds_to_utc_calendar");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/eutc_pkg.sv
hdl/eutc_if.sv
hdl/epoch_seconds_to_utc_calendar.sv
sim/epoch_seconds_to_utc_calendar_test.sv
